// ===== hdl/rau_pkg.sv =====
// types and constants shared by the rational arithmetic unit
package rau_pkg;

    localparam int WIDTH = 32;
    localparam int MW    = 2 * WIDTH + 2;
    localparam int CW    = $clog2(MW + 1);

    typedef enum logic [3:0] {
        FN_ADD, FN_SUB, FN_MUL, FN_DIV, FN_FLOORDIV, FN_MOD,
        FN_SHL, FN_SHR, FN_AND, FN_XOR, FN_OR
    } rau_func_t;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_ZERO_DEN  = 3'd1;
    localparam logic [2:0] ST_NON_INT   = 3'd2;
    localparam logic [2:0] ST_BAD_SHIFT = 3'd3;
    localparam logic [2:0] ST_OVERFLOW  = 3'd4;
    localparam logic [2:0] ST_BAD_CODE  = 3'd5;

    typedef enum logic [4:0] {
        S_IDLE, S_CHECK, S_RA_GCD, S_RA_DN, S_RA_DD, S_RB_GCD, S_RB_DN, S_RB_DD,
        S_DISPATCH, S_MUL1, S_MUL2, S_MUL3, S_COMB, S_R_GCD, S_R_DN, S_R_DD,
        S_FDIV, S_MOD, S_SHL, S_SHR
    } rau_state_t;

    typedef enum logic [2:0] {
        G_INIT, G_TWO, G_AODD, G_LOOP, G_SHL
    } rau_gcd_t;

    typedef struct packed {
        logic [3:0]              func;
        logic signed [WIDTH-1:0] a_num;
        logic signed [WIDTH-1:0] a_den;
        logic signed [WIDTH-1:0] b_num;
        logic signed [WIDTH-1:0] b_den;
    } rau_req_t;

    typedef struct packed {
        logic signed [WIDTH-1:0] r_num;
        logic signed [WIDTH-1:0] r_den;
        logic [2:0]              status;
    } rau_rsp_t;

endpackage

// ===== hdl/rational_arithmetic_unit.sv =====
// rational arithmetic unit: sequencer around one shared gcd / divide / multiply datapath
// an invalid code or a zero input denominator ends the request at the check; otherwise the unit runs
//   four to six restoring divisions, up to three multiplies and up to three binary gcd loops,
//   fewest for the bitwise ops and most for add/sub
// throughput: one request at a time; busy drops in the done cycle, so the next request may go then
// the done strobe lasts exactly one cycle and the result holds until the next one; the receiver cannot stall
// reset: asynchronous active-low rst_n returns the sequencer to idle, no strobe pending
module rational_arithmetic_unit
    import rau_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  rau_req_t request,
    output logic     done,
    output rau_rsp_t result
);

    localparam logic [MW-1:0] HALF = MW'(1) << (WIDTH - 1);

    // sequencer and captured operands
    rau_state_t       state_reg, state_next;
    rau_gcd_t         gph_reg, gph_next;
    logic [3:0]       func_reg, func_next;
    logic             an_reg, ad_reg, bn_reg, bd_reg;
    logic             an_next, ad_next, bn_next, bd_next;
    logic [WIDTH-1:0] anm_reg, adm_reg, bnm_reg, bdm_reg;
    logic [WIDTH-1:0] anm_next, adm_next, bnm_next, bdm_next;

    // shared wide datapath
    logic [MW-1:0] x_reg, y_reg, q_reg, r_reg, g_reg, nm_reg, dm_reg;
    logic [MW-1:0] x_next, y_next, q_next, r_next, g_next, nm_next, dm_next;
    logic          nneg_reg, dneg_reg, nneg_next, dneg_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          sticky_reg, sticky_next;

    logic     done_reg, done_next;
    rau_rsp_t rsp_reg, rsp_next;

    function automatic logic [WIDTH-1:0] mag_of(input logic [WIDTH-1:0] v);
        mag_of = v[WIDTH-1] ? (~v + WIDTH'(1)) : v;
    endfunction

    function automatic logic [WIDTH-1:0] word_of(input logic neg, input logic [MW-1:0] m);
        word_of = neg ? (~m[WIDTH-1:0] + WIDTH'(1)) : m[WIDTH-1:0];
    endfunction

    function automatic logic fits(input logic neg, input logic [MW-1:0] m);
        fits = neg ? (m <= HALF) : (m <= HALF - MW'(1));
    endfunction

    // binary gcd step on x/y, cnt holds the common power of two
    logic          g_done;
    logic [MW-1:0] g_val, gx, gy;
    logic [CW-1:0] gc;
    rau_gcd_t      gp;

    always_comb
    begin
        gx     = x_reg;
        gy     = y_reg;
        gc     = cnt_reg;
        gp     = gph_reg;
        g_done = 1'b0;
        g_val  = x_reg;
        unique case (gph_reg)
            G_INIT:
            begin
                if (x_reg == '0)
                begin
                    g_done = 1'b1;
                    g_val  = y_reg;
                end
                else if (y_reg == '0)
                begin
                    g_done = 1'b1;
                end
                else
                begin
                    gp = G_TWO;
                end
            end
            G_TWO:
            begin
                if (x_reg[0] | y_reg[0])
                begin
                    gp = G_AODD;
                end
                else
                begin
                    gx = x_reg >> 1;
                    gy = y_reg >> 1;
                    gc = cnt_reg + CW'(1);
                end
            end
            G_AODD:
            begin
                if (x_reg[0])
                begin
                    gp = G_LOOP;
                end
                else
                begin
                    gx = x_reg >> 1;
                end
            end
            G_LOOP:
            begin
                if (!y_reg[0])
                begin
                    gy = y_reg >> 1;
                end
                else if (x_reg > y_reg)
                begin
                    gx = y_reg;
                    gy = x_reg - y_reg;
                end
                else
                begin
                    gy = y_reg - x_reg;
                    if (y_reg == x_reg)
                    begin
                        gp = G_SHL;
                    end
                end
            end
            G_SHL:
            begin
                if (cnt_reg == '0)
                begin
                    g_done = 1'b1;
                end
                else
                begin
                    gx = x_reg << 1;
                    gc = cnt_reg - CW'(1);
                end
            end
            default:
            begin
                gp = G_INIT;
            end
        endcase
    end

    // restoring divide step: x shifts out the dividend, y is the divisor
    logic [MW-1:0] rs;
    logic          rs_ge;
    assign rs    = {r_reg[MW-2:0], x_reg[MW-1]};
    assign rs_ge = (rs >= y_reg);

    // signs and operand picks for the product steps
    logic is_addsub, is_div, a_int, b_int;
    assign is_addsub = (func_reg == FN_ADD) || (func_reg == FN_SUB);
    assign is_div    = (func_reg == FN_DIV) || (func_reg == FN_FLOORDIV);
    assign a_int     = (anm_reg == '0) || (!ad_reg && anm_reg != '0 && adm_reg == WIDTH'(1));
    assign b_int     = (bnm_reg == '0) || (!bd_reg && bdm_reg == WIDTH'(1));

    logic          fin;
    logic [2:0]    fst;
    logic [WIDTH-1:0] fnum, fden;
    logic [MW-1:0] fq, sum_m;
    logic          fng, t_neg, sum_neg;
    logic [WIDTH-1:0] wa, wb;

    always_comb
    begin
        state_next  = state_reg;
        gph_next    = gph_reg;
        func_next   = func_reg;
        an_next     = an_reg;
        ad_next     = ad_reg;
        bn_next     = bn_reg;
        bd_next     = bd_reg;
        anm_next    = anm_reg;
        adm_next    = adm_reg;
        bnm_next    = bnm_reg;
        bdm_next    = bdm_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        q_next      = q_reg;
        r_next      = r_reg;
        g_next      = g_reg;
        nm_next     = nm_reg;
        dm_next     = dm_reg;
        nneg_next   = nneg_reg;
        dneg_next   = dneg_reg;
        cnt_next    = cnt_reg;
        sticky_next = sticky_reg;
        done_next   = 1'b0;
        rsp_next    = rsp_reg;
        fin         = 1'b0;
        fst         = ST_OK;
        fnum        = '0;
        fden        = '0;
        fq          = q_reg;
        fng         = 1'b0;
        t_neg       = 1'b0;
        sum_m       = nm_reg;
        sum_neg     = nneg_reg;
        wa          = word_of(an_reg, MW'(anm_reg));
        wb          = word_of(bn_reg, MW'(bnm_reg));

        // the unit steps by default in every state but the shift states; launches below override
        if (state_reg == S_RA_GCD || state_reg == S_RB_GCD || state_reg == S_R_GCD)
        begin
            x_next   = gx;
            y_next   = gy;
            cnt_next = gc;
            gph_next = gp;
        end
        else if (state_reg == S_MUL1 || state_reg == S_MUL2 || state_reg == S_MUL3)
        begin
            r_next   = y_reg[0] ? r_reg + x_reg : r_reg;
            x_next   = x_reg << 1;
            y_next   = y_reg >> 1;
            cnt_next = cnt_reg - CW'(1);
        end
        else if (state_reg != S_SHL && state_reg != S_SHR)
        begin
            r_next   = rs_ge ? rs - y_reg : rs;
            q_next   = {q_reg[MW-2:0], rs_ge};
            x_next   = x_reg << 1;
            cnt_next = cnt_reg - CW'(1);
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    func_next  = request.func;
                    an_next    = request.a_num[WIDTH-1];
                    ad_next    = request.a_den[WIDTH-1];
                    bn_next    = request.b_num[WIDTH-1];
                    bd_next    = request.b_den[WIDTH-1];
                    anm_next   = mag_of(request.a_num);
                    adm_next   = mag_of(request.a_den);
                    bnm_next   = mag_of(request.b_num);
                    bdm_next   = mag_of(request.b_den);
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (func_reg > FN_OR)
                begin
                    fin = 1'b1;
                    fst = ST_BAD_CODE;
                end
                else if (adm_reg == '0 || bdm_reg == '0)
                begin
                    fin = 1'b1;
                    fst = ST_ZERO_DEN;
                end
                else
                begin
                    x_next     = MW'(anm_reg);
                    y_next     = MW'(adm_reg);
                    cnt_next   = '0;
                    gph_next   = G_INIT;
                    state_next = S_RA_GCD;
                end
            end
            S_RA_GCD, S_RB_GCD, S_R_GCD:
            begin
                if (g_done)
                begin
                    g_next   = g_val;
                    y_next   = g_val;
                    r_next   = '0;
                    q_next   = '0;
                    cnt_next = CW'(MW);
                    if (state_reg == S_RA_GCD)
                    begin
                        x_next     = MW'(anm_reg);
                        state_next = S_RA_DN;
                    end
                    else if (state_reg == S_RB_GCD)
                    begin
                        x_next     = MW'(bnm_reg);
                        state_next = S_RB_DN;
                    end
                    else
                    begin
                        x_next     = nm_reg;
                        state_next = S_R_DN;
                    end
                end
            end
            S_RA_DN, S_RB_DN, S_R_DN:
            begin
                if (cnt_reg == '0)
                begin
                    y_next   = g_reg;
                    r_next   = '0;
                    q_next   = '0;
                    cnt_next = CW'(MW);
                    if (state_reg == S_RA_DN)
                    begin
                        anm_next   = q_reg[WIDTH-1:0];
                        x_next     = MW'(adm_reg);
                        state_next = S_RA_DD;
                    end
                    else if (state_reg == S_RB_DN)
                    begin
                        bnm_next   = q_reg[WIDTH-1:0];
                        x_next     = MW'(bdm_reg);
                        state_next = S_RB_DD;
                    end
                    else
                    begin
                        nm_next    = q_reg;
                        x_next     = dm_reg;
                        state_next = S_R_DD;
                    end
                end
            end
            S_RA_DD:
            begin
                if (cnt_reg == '0)
                begin
                    adm_next   = q_reg[WIDTH-1:0];
                    x_next     = MW'(bnm_reg);
                    y_next     = MW'(bdm_reg);
                    cnt_next   = '0;
                    gph_next   = G_INIT;
                    state_next = S_RB_GCD;
                end
            end
            S_RB_DD:
            begin
                if (cnt_reg == '0)
                begin
                    bdm_next   = q_reg[WIDTH-1:0];
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (func_reg <= FN_FLOORDIV)
                begin
                    // first product: numerator (or a.num * b.den for add/sub)
                    r_next   = '0;
                    cnt_next = CW'(WIDTH);
                    x_next   = MW'(anm_reg);
                    if (is_div)
                    begin
                        y_next    = MW'(bdm_reg);
                        nneg_next = bd_reg ^ an_reg;
                    end
                    else if (is_addsub)
                    begin
                        y_next    = MW'(bdm_reg);
                        nneg_next = an_reg ^ bd_reg;
                    end
                    else
                    begin
                        y_next    = MW'(bnm_reg);
                        nneg_next = bn_reg ^ an_reg;
                    end
                    state_next = S_MUL1;
                end
                else if (!a_int || !b_int)
                begin
                    fin = 1'b1;
                    fst = ST_NON_INT;
                end
                else
                begin
                    unique case (func_reg)
                        FN_MOD:
                        begin
                            if (bnm_reg == '0)
                            begin
                                fin = 1'b1;
                                fst = ST_ZERO_DEN;
                            end
                            else
                            begin
                                x_next     = MW'(anm_reg);
                                y_next     = MW'(bnm_reg);
                                r_next     = '0;
                                q_next     = '0;
                                cnt_next   = CW'(MW);
                                state_next = S_MOD;
                            end
                        end
                        FN_SHL, FN_SHR:
                        begin
                            if (bn_reg || bnm_reg >= WIDTH'(WIDTH))
                            begin
                                fin = 1'b1;
                                fst = ST_BAD_SHIFT;
                            end
                            else
                            begin
                                x_next      = MW'(anm_reg);
                                cnt_next    = CW'(bnm_reg);
                                sticky_next = 1'b0;
                                state_next  = (func_reg == FN_SHL) ? S_SHL : S_SHR;
                            end
                        end
                        FN_AND:
                        begin
                            fin  = 1'b1;
                            fnum = wa & wb;
                            fden = WIDTH'(1);
                        end
                        FN_XOR:
                        begin
                            fin  = 1'b1;
                            fnum = wa ^ wb;
                            fden = WIDTH'(1);
                        end
                        default:
                        begin
                            fin  = 1'b1;
                            fnum = wa | wb;
                            fden = WIDTH'(1);
                        end
                    endcase
                end
            end
            S_MUL1:
            begin
                if (cnt_reg == '0)
                begin
                    // second product: denominator
                    nm_next    = r_reg;
                    r_next     = '0;
                    cnt_next   = CW'(WIDTH);
                    x_next     = MW'(adm_reg);
                    y_next     = is_div ? MW'(bnm_reg) : MW'(bdm_reg);
                    dneg_next  = is_div ? (bn_reg ^ ad_reg) : (bd_reg ^ ad_reg);
                    state_next = S_MUL2;
                end
            end
            S_MUL2:
            begin
                if (cnt_reg == '0)
                begin
                    dm_next = r_reg;
                    if (is_addsub)
                    begin
                        r_next     = '0;
                        cnt_next   = CW'(WIDTH);
                        x_next     = MW'(adm_reg);
                        y_next     = MW'(bnm_reg);
                        state_next = S_MUL3;
                    end
                    else
                    begin
                        state_next = S_COMB;
                    end
                end
            end
            S_MUL3:
            begin
                if (cnt_reg == '0)
                begin
                    // signed sum of the two cross products
                    t_neg = ad_reg ^ bn_reg ^ (func_reg == FN_SUB);
                    if (nneg_reg == t_neg)
                    begin
                        sum_m = nm_reg + r_reg;
                    end
                    else if (nm_reg >= r_reg)
                    begin
                        sum_m = nm_reg - r_reg;
                    end
                    else
                    begin
                        sum_m   = r_reg - nm_reg;
                        sum_neg = t_neg;
                    end
                    nm_next    = sum_m;
                    nneg_next  = sum_neg;
                    state_next = S_COMB;
                end
            end
            S_COMB:
            begin
                if (dm_reg == '0)
                begin
                    fin = 1'b1;
                    fst = ST_ZERO_DEN;
                end
                else if (func_reg == FN_FLOORDIV)
                begin
                    x_next     = nm_reg;
                    y_next     = dm_reg;
                    r_next     = '0;
                    q_next     = '0;
                    cnt_next   = CW'(MW);
                    state_next = S_FDIV;
                end
                else
                begin
                    x_next     = nm_reg;
                    y_next     = dm_reg;
                    cnt_next   = '0;
                    gph_next   = G_INIT;
                    state_next = S_R_GCD;
                end
            end
            S_R_DD:
            begin
                if (cnt_reg == '0)
                begin
                    fin = 1'b1;
                    if (!fits(nneg_reg, nm_reg) || !fits(dneg_reg, q_reg))
                    begin
                        fst = ST_OVERFLOW;
                    end
                    else
                    begin
                        fnum = word_of(nneg_reg, nm_reg);
                        fden = word_of(dneg_reg, q_reg);
                    end
                end
            end
            S_FDIV:
            begin
                if (cnt_reg == '0)
                begin
                    // floor: round a negative inexact quotient away from zero
                    fng = nneg_reg ^ dneg_reg;
                    if (fng && r_reg != '0)
                    begin
                        fq = q_reg + MW'(1);
                    end
                    if (fq == '0)
                    begin
                        fng = 1'b0;
                    end
                    fin = 1'b1;
                    if (!fits(fng, fq))
                    begin
                        fst = ST_OVERFLOW;
                    end
                    else
                    begin
                        fnum = word_of(fng, fq);
                        fden = WIDTH'(1);
                    end
                end
            end
            S_MOD:
            begin
                if (cnt_reg == '0)
                begin
                    fin  = 1'b1;
                    fnum = word_of(an_reg && r_reg != '0, r_reg);
                    fden = WIDTH'(1);
                end
            end
            S_SHL:
            begin
                if (cnt_reg == '0)
                begin
                    fin = 1'b1;
                    if (!fits(an_reg, x_reg))
                    begin
                        fst = ST_OVERFLOW;
                    end
                    else
                    begin
                        fnum = word_of(an_reg, x_reg);
                        fden = WIDTH'(1);
                    end
                end
                else
                begin
                    x_next   = x_reg << 1;
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            S_SHR:
            begin
                if (cnt_reg == '0)
                begin
                    // arithmetic shift of a negative value rounds the magnitude up
                    fq   = x_reg + MW'(an_reg && sticky_reg);
                    fin  = 1'b1;
                    fnum = word_of(an_reg && fq != '0, fq);
                    fden = WIDTH'(1);
                end
                else
                begin
                    sticky_next = sticky_reg | x_reg[0];
                    x_next      = x_reg >> 1;
                    cnt_next    = cnt_reg - CW'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (fin)
        begin
            done_next       = 1'b1;
            state_next      = S_IDLE;
            rsp_next.status = fst;
            rsp_next.r_num  = (fst == ST_OK) ? fnum : '0;
            rsp_next.r_den  = (fst == ST_OK) ? fden : '0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            gph_reg   <= G_INIT;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            gph_reg   <= gph_next;
            done_reg  <= done_next;
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        an_reg     <= an_next;
        ad_reg     <= ad_next;
        bn_reg     <= bn_next;
        bd_reg     <= bd_next;
        anm_reg    <= anm_next;
        adm_reg    <= adm_next;
        bnm_reg    <= bnm_next;
        bdm_reg    <= bdm_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        q_reg      <= q_next;
        r_reg      <= r_next;
        g_reg      <= g_next;
        nm_reg     <= nm_next;
        dm_reg     <= dm_next;
        nneg_reg   <= nneg_next;
        dneg_reg   <= dneg_next;
        cnt_reg    <= cnt_next;
        sticky_reg <= sticky_next;
        rsp_reg    <= rsp_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = rsp_reg;

`ifndef SYNTHESIS
    // a result only follows a request in flight
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("done without a request in flight");

    // an accepted request keeps the unit busy next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("request accepted but unit not busy");

    // any error status carries a zero fraction
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != ST_OK) |-> (result.r_num == '0 && result.r_den == '0))
        else $error("error result with nonzero fraction");

    // an ok result never has a zero denominator
    a_ok_den: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == ST_OK) |-> (result.r_den != '0))
        else $error("ok result with zero denominator");
`endif

endmodule
